[hw/rtl/acpea_pkg.sv]
// shared types and constants for the ac power energy accumulator
// no dependencies; imported by every module of the block

package acpea_pkg;

   localparam int POWER_W     = 31;
   localparam int ENERGY_W    = 48;
   localparam int TICK_W      = 6;
   localparam int NUM_PERIODS = 5;
   localparam int SAMPLE_W    = 16;
   localparam int VI_W        = 2 * SAMPLE_W;
   localparam int PROD_W      = VI_W + SAMPLE_W;

   // bit positions in the tick vector: second, then minute .. year
   localparam int TICK_SECOND = 0;

   localparam logic [POWER_W-1:0]  POWER_MAX  = {POWER_W{1'b1}};
   localparam logic [ENERGY_W-1:0] ENERGY_MAX = {ENERGY_W{1'b1}};

   typedef struct packed {
      logic [SAMPLE_W-1:0] voltage;
      logic [SAMPLE_W-1:0] current;
      logic [SAMPLE_W-1:0] power_factor;
      logic                second_tick;
      logic                minute_tick;
      logic                hour_tick;
      logic                day_tick;
      logic                month_tick;
      logic                year_tick;
   } req_type;

   typedef struct packed {
      logic [POWER_W-1:0]  power;
      logic [POWER_W-1:0]  energy_second;
      logic [ENERGY_W-1:0] energy_minute;
      logic [ENERGY_W-1:0] energy_hour;
      logic [ENERGY_W-1:0] energy_day;
      logic [ENERGY_W-1:0] energy_month;
      logic [ENERGY_W-1:0] energy_year;
      logic                energy_updated;
   } rsp_type;

   // one item as it travels from the front end to the back end
   typedef struct packed {
      logic [POWER_W-1:0] power;
      logic [TICK_W-1:0]  ticks;
   } item_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_DIV,
      BK_FIN
   } back_state_type;

endpackage

[hw/rtl/acpea_front.sv]
// front end: takes request transfers and forms the saturated power in two stages
// depends on acpea_pkg

module acpea_front import acpea_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_stall,
   input  req_type  req_data,
   output logic     q_push,
   output item_type q_item,
   input  logic     q_full
);

   logic                 s1_valid_ff, s1_valid_in;
   logic [VI_W-1:0]      vi_ff, vi_in;
   logic [SAMPLE_W-1:0]  pf_ff, pf_in;
   logic [TICK_W-1:0]    t1_ff, t1_in;
   logic                 s2_valid_ff, s2_valid_in;
   item_type             item2_ff, item2_in;

   logic                 s2_free, s1_move, s1_free, accept;
   logic [PROD_W-1:0]    prod;
   logic [POWER_W:0]     pwr_raw;

   assign s2_free   = !s2_valid_ff || !q_full;
   assign s1_move   = s1_valid_ff && s2_free;
   assign s1_free   = !s1_valid_ff || s1_move;
   assign req_stall = !s1_free;
   assign accept    = req_valid && s1_free;

   assign prod    = PROD_W'(vi_ff) * PROD_W'(pf_ff);
   assign pwr_raw = prod[PROD_W-1:SAMPLE_W];

   always_comb begin
      s1_valid_in = s1_valid_ff;
      vi_in       = vi_ff;
      pf_in       = pf_ff;
      t1_in       = t1_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
         vi_in       = VI_W'(req_data.voltage) * VI_W'(req_data.current);
         pf_in       = req_data.power_factor;
         t1_in       = {req_data.year_tick, req_data.month_tick, req_data.day_tick,
                        req_data.hour_tick, req_data.minute_tick, req_data.second_tick};
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      s2_valid_in = s2_valid_ff && q_full;
      item2_in    = item2_ff;
      if (s1_move) begin
         s2_valid_in    = 1'b1;
         // power factor above one can push the product past 31 bits
         item2_in.power = pwr_raw[POWER_W] ? POWER_MAX : pwr_raw[POWER_W-1:0];
         item2_in.ticks = t1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
      vi_ff    <= vi_in;
      pf_ff    <= pf_in;
      t1_ff    <= t1_in;
      item2_ff <= item2_in;
   end

   assign q_push = s2_valid_ff;
   assign q_item = item2_ff;

endmodule

[hw/rtl/acpea_queue.sv]
// two-entry queue between the front end and the back end
// depends on acpea_pkg

module acpea_queue import acpea_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   output logic     full,
   input  logic     pop,
   output logic     head_valid,
   output item_type head_item
);

   logic [1:0] count_ff, count_in;
   item_type   d0_ff, d0_in;
   item_type   d1_ff, d1_in;
   logic       do_push, do_pop;
   logic [1:0] wr_idx;

   assign full       = (count_ff == 2'd2);
   assign head_valid = (count_ff != 2'd0);
   assign head_item  = d0_ff;
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;
   assign wr_idx     = count_ff - {1'b0, do_pop};

   always_comb begin
      d0_in    = d0_ff;
      d1_in    = d1_ff;
      count_in = count_ff + {1'b0, do_push} - {1'b0, do_pop};
      if (do_pop) begin
         d0_in = d1_ff;
      end
      if (do_push) begin
         if (wr_idx == 2'd0) begin
            d0_in = push_item;
         end else begin
            d1_in = push_item;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
      d0_ff <= d0_in;
      d1_ff <= d1_in;
   end

endmodule

[hw/rtl/acpea_div.sv]
// window average by reciprocal multiplication, summing four partial products in turn
// depends on acpea_pkg

module acpea_div import acpea_pkg::*; #(
   parameter int WINDOW_SAMPLES = 50,
   parameter int DIVIDEND_W     = 38
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   output logic [DIVIDEND_W-1:0] quotient,
   output logic                  done
);

   // floor(x * RECIP / 2^SHIFT) equals floor(x / WINDOW_SAMPLES) for every dividend
   localparam int LOG_W   = $clog2(WINDOW_SAMPLES);
   localparam int SHIFT   = DIVIDEND_W + LOG_W;
   localparam int RECIP_W = DIVIDEND_W + 1;
   localparam int PART_W  = (RECIP_W + 1) / 2;
   localparam int OPND_W  = 2 * PART_W;
   localparam int ACC_W   = 4 * PART_W;
   localparam logic [63:0] RECIP_WIDE =
      ((64'd1 << SHIFT) / 64'(WINDOW_SAMPLES)) + 64'd1;
   localparam logic [OPND_W-1:0] RECIP = RECIP_WIDE[OPND_W-1:0];

   logic [OPND_W-1:0] x_ff, x_in;
   logic [ACC_W-1:0]  acc_ff, acc_in;
   logic [1:0]        step_ff, step_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [PART_W-1:0] op_a, op_b;
   logic [OPND_W-1:0] part;
   logic [ACC_W-1:0]  part_sh;

   // step bit 1 picks the dividend half, bit 0 the reciprocal half
   assign op_a = step_ff[1] ? x_ff[OPND_W-1:PART_W] : x_ff[PART_W-1:0];
   assign op_b = step_ff[0] ? RECIP[OPND_W-1:PART_W] : RECIP[PART_W-1:0];
   assign part = OPND_W'(op_a) * OPND_W'(op_b);

   always_comb begin
      case (step_ff)
         2'd0:    part_sh = ACC_W'(part);
         2'd3:    part_sh = ACC_W'(part) << (2 * PART_W);
         default: part_sh = ACC_W'(part) << PART_W;
      endcase
   end

   always_comb begin
      x_in    = x_ff;
      acc_in  = acc_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         x_in    = OPND_W'(dividend);
         acc_in  = '0;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         acc_in  = acc_ff + part_sh;
         step_in = step_ff + 1'b1;
         if (step_ff == 2'd3) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      x_ff    <= x_in;
      acc_ff  <= acc_in;
      step_ff <= step_in;
   end

   assign quotient = DIVIDEND_W'(acc_ff >> SHIFT);
   assign done     = done_ff;

endmodule

[hw/rtl/acpea_back.sv]
// back end: window sum, pending ticks, period accumulators and the result register
// depends on acpea_pkg and acpea_div

module acpea_back import acpea_pkg::*; #(
   parameter int WINDOW_SAMPLES = 50
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     item_valid,
   input  item_type item,
   output logic     item_pop,
   output logic     rsp_valid,
   input  logic     rsp_stall,
   output rsp_type  rsp_data
);

   localparam int CNT_W      = $clog2(WINDOW_SAMPLES);
   localparam int SUM_W      = POWER_W + CNT_W;
   localparam int DIVIDEND_W = SUM_W + 1;
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(WINDOW_SAMPLES - 1);

   back_state_type       state_ff, state_in;
   logic [CNT_W-1:0]     fill_ff, fill_in;
   logic [SUM_W-1:0]     sum_ff, sum_in;
   logic [TICK_W-1:0]    latched_ff, latched_in;
   logic [POWER_W-1:0]   second_ff, second_in;
   logic [ENERGY_W-1:0]  period_ff [NUM_PERIODS];
   logic [ENERGY_W-1:0]  period_in [NUM_PERIODS];
   logic [POWER_W-1:0]   pwr_ff, pwr_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_data_ff, rsp_data_in;

   logic                  out_free, full, div_start, div_done, finish, load_rsp;
   logic [TICK_W-1:0]     ticks_all;
   logic [DIVIDEND_W-1:0] dividend, quotient;
   logic [ENERGY_W:0]     acc_sum [NUM_PERIODS];

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign ticks_all = latched_ff | item.ticks;
   assign full      = (fill_ff == FULL_COUNT);
   assign dividend  = DIVIDEND_W'(sum_ff) + DIVIDEND_W'(item.power);

   acpea_div #(
      .WINDOW_SAMPLES (WINDOW_SAMPLES),
      .DIVIDEND_W     (DIVIDEND_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dividend),
      .quotient (quotient),
      .done     (div_done)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (item_valid && out_free && full && ticks_all[TICK_SECOND]) begin
               state_in = BK_DIV;
            end
         end
         BK_DIV: begin
            if (div_done) begin
               state_in = BK_FIN;
            end
         end
         BK_FIN: begin
            if (out_free) begin
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      item_pop  = 1'b0;
      div_start = 1'b0;
      finish    = 1'b0;
      case (state_ff)
         BK_IDLE: begin
            item_pop  = item_valid && out_free;
            div_start = item_valid && out_free && full && ticks_all[TICK_SECOND];
         end
         BK_FIN: begin
            finish = out_free;
         end
         default: begin
            item_pop = 1'b0;
         end
      endcase
   end

   assign load_rsp = (item_pop && !div_start) || finish;

   always_comb begin
      for (int k = 0; k < NUM_PERIODS; k++) begin
         acc_sum[k] = {1'b0, period_ff[k]} + (ENERGY_W + 1)'(quotient[POWER_W-1:0]);
      end
   end

   always_comb begin
      fill_in    = fill_ff;
      sum_in     = sum_ff;
      latched_in = latched_ff;
      second_in  = second_ff;
      pwr_in     = pwr_ff;
      for (int k = 0; k < NUM_PERIODS; k++) begin
         period_in[k] = period_ff[k];
      end
      if (item_pop) begin
         pwr_in = item.power;
         if (!full) begin
            sum_in     = sum_ff + SUM_W'(item.power);
            fill_in    = fill_ff + 1'b1;
            latched_in = ticks_all;
         end else begin
            // window full: period boundaries clear first
            for (int k = 0; k < NUM_PERIODS; k++) begin
               if (ticks_all[k+1]) begin
                  period_in[k] = '0;
               end
            end
            latched_in = '0;
         end
      end
      if (finish) begin
         second_in = quotient[POWER_W-1:0];
         for (int k = 0; k < NUM_PERIODS; k++) begin
            period_in[k] = acc_sum[k][ENERGY_W] ? ENERGY_MAX : acc_sum[k][ENERGY_W-1:0];
         end
         sum_in     = '0;
         fill_in    = '0;
         latched_in = '0;
      end
   end

   always_comb begin
      rsp_data_in.power          = item_pop ? item.power : pwr_ff;
      rsp_data_in.energy_second  = second_in;
      rsp_data_in.energy_minute  = period_in[0];
      rsp_data_in.energy_hour    = period_in[1];
      rsp_data_in.energy_day     = period_in[2];
      rsp_data_in.energy_month   = period_in[3];
      rsp_data_in.energy_year    = period_in[4];
      rsp_data_in.energy_updated = finish || (item_pop && full);
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         fill_ff      <= '0;
         sum_ff       <= '0;
         latched_ff   <= '0;
         second_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < NUM_PERIODS; k++) begin
            period_ff[k] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         sum_ff       <= sum_in;
         latched_ff   <= latched_in;
         second_ff    <= second_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int k = 0; k < NUM_PERIODS; k++) begin
            period_ff[k] <= period_in[k];
         end
      end
      pwr_ff <= pwr_in;
      if (load_rsp) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[hw/rtl/ac_power_energy_accumulator_unit.sv]
// ac power energy accumulator, top level
// depends on acpea_pkg, acpea_front, acpea_queue, acpea_back (and acpea_div)
//
// usage:
//  - req channel: one voltage, current and power-factor sample plus six
//    boundary ticks per transfer; rsp channel: exactly one result per request
//  - a transfer happens when valid is high and stall is low
//  - when the item needs no averaging, its result passes through both front-end
//    stages, the queue and the result register; the back end then takes one
//    item per cycle while no result waits on rsp_stall
//  - an item that completes the window while a second tick is pending or comes
//    with it forms the average by reciprocal multiplication in four partial
//    products; the back end takes no further item until its result is loaded
//  - the front end forms power with two multiplier stages and feeds a
//    two-entry queue, so it keeps taking requests while the back end averages
//    or a result waits; req_stall rises only once the queue and both stages fill
//  - the result register holds its value while rsp_stall is high
//  - synchronous reset clears the window, pending ticks, second energy and all
//    period accumulators; no result is pending after reset

module ac_power_energy_accumulator_unit import acpea_pkg::*; #(
   parameter int WINDOW_SAMPLES = 50
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic     q_push, q_full, head_valid, head_pop;
   item_type q_item, head_item;

   acpea_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_push    (q_push),
      .q_item    (q_item),
      .q_full    (q_full)
   );

   acpea_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_item  (q_item),
      .full       (q_full),
      .pop        (head_pop),
      .head_valid (head_valid),
      .head_item  (head_item)
   );

   acpea_back #(
      .WINDOW_SAMPLES (WINDOW_SAMPLES)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (head_valid),
      .item       (head_item),
      .item_pop   (head_pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule

[verif/acpea_energy_checker.sv]
// checker for the ac power energy accumulator: watches both channels,
// predicts every result from the accepted samples and compares field by field
// depends on acpea_pkg

module acpea_energy_checker import acpea_pkg::*; #(
   parameter int WINDOW_SAMPLES = 50
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  req_type     req_data,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  rsp_type     rsp_data,
   output int unsigned fail_count,
   output int unsigned pending
);

   localparam int POWER_SHIFT = 16;

   // predicted block state
   logic [36:0]          window_total;
   logic [POWER_W-1:0]   tail_power;
   logic [5:0]           fill_level;
   logic [TICK_W-1:0]    held_ticks;
   logic [POWER_W-1:0]   second_avg;
   logic [ENERGY_W-1:0]  period_acc [NUM_PERIODS];

   rsp_type     expected_rsps [$];
   int unsigned errors = 0;

   function automatic logic [POWER_W-1:0] sample_power(req_type r);
      logic [PROD_W-1:0] product;
      product = PROD_W'(r.voltage) * PROD_W'(r.current) * PROD_W'(r.power_factor);
      product = product >> POWER_SHIFT;
      if (product > PROD_W'(POWER_MAX)) begin
         return POWER_MAX;
      end
      return product[POWER_W-1:0];
   endfunction

   task automatic predict_energy(input req_type r);
      logic [TICK_W-1:0]  ticks;
      logic [POWER_W-1:0] p;
      logic [ENERGY_W:0]  total;
      logic [63:0]        avg;
      rsp_type            e;
      ticks = {r.year_tick, r.month_tick, r.day_tick, r.hour_tick, r.minute_tick,
               r.second_tick};
      p = sample_power(r);
      held_ticks = held_ticks | ticks;
      e = '0;
      if (fill_level < WINDOW_SAMPLES - 1) begin
         window_total = window_total + 37'(p);
         fill_level   = fill_level + 1'b1;
      end else begin
         tail_power = p;
         e.energy_updated = 1'b1;
         // period clears come before the second energy is added
         for (int k = 0; k < NUM_PERIODS; k++) begin
            if (held_ticks[TICK_SECOND + 1 + k]) period_acc[k] = '0;
         end
         if (held_ticks[TICK_SECOND]) begin
            avg = 64'(window_total);
            avg = (avg + 64'(tail_power)) / 64'(WINDOW_SAMPLES);
            second_avg = avg[POWER_W-1:0];
            for (int k = 0; k < NUM_PERIODS; k++) begin
               total = {1'b0, period_acc[k]} + (ENERGY_W + 1)'(second_avg);
               period_acc[k] = total[ENERGY_W] ? ENERGY_MAX : total[ENERGY_W-1:0];
            end
            window_total = '0;
            tail_power   = '0;
            fill_level   = '0;
         end
         held_ticks = '0;
      end
      e.power         = p;
      e.energy_second = second_avg;
      e.energy_minute = period_acc[0];
      e.energy_hour   = period_acc[1];
      e.energy_day    = period_acc[2];
      e.energy_month  = period_acc[3];
      e.energy_year   = period_acc[4];
      expected_rsps.push_back(e);
   endtask

   task automatic check_field(input string field, input logic [63:0] want,
                              input logic [63:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
         errors++;
      end
   endtask

   task automatic check_result(input rsp_type got);
      rsp_type want;
      if (expected_rsps.size() == 0) begin
         $display("%0t: result transfer with none expected, expected nothing, actual power %0d",
                  $time, got.power);
         errors++;
      end else begin
         want = expected_rsps.pop_front();
         check_field("power",          64'(want.power),          64'(got.power));
         check_field("energy_second",  64'(want.energy_second),  64'(got.energy_second));
         check_field("energy_minute",  64'(want.energy_minute),  64'(got.energy_minute));
         check_field("energy_hour",    64'(want.energy_hour),    64'(got.energy_hour));
         check_field("energy_day",     64'(want.energy_day),     64'(got.energy_day));
         check_field("energy_month",   64'(want.energy_month),   64'(got.energy_month));
         check_field("energy_year",    64'(want.energy_year),    64'(got.energy_year));
         check_field("energy_updated", 64'(want.energy_updated), 64'(got.energy_updated));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         window_total = '0;
         tail_power   = '0;
         fill_level   = '0;
         held_ticks   = '0;
         second_avg   = '0;
         for (int k = 0; k < NUM_PERIODS; k++) period_acc[k] = '0;
         expected_rsps.delete();
      end else begin
         if (rsp_valid && !rsp_stall) check_result(rsp_data);
         if (req_valid && !req_stall) predict_energy(req_data);
      end
      fail_count <= errors;
      pending    <= expected_rsps.size();
   end

endmodule

[verif/ac_power_energy_accumulator_unit_tb.sv]
// testbench top for the ac power energy accumulator: drives samples with
// random gaps and result stalls, gives the verdict
// depends on acpea_pkg, acpea_energy_checker and the block's rtl

module ac_power_energy_accumulator_unit_tb import acpea_pkg::*; ();

   localparam int WINDOW_SAMPLES = 50;
   localparam int ITEM_COUNT     = 1700;
   localparam int PAUSE_AT       = 850;
   localparam int QUIET_LIMIT    = 3000;
   localparam int DRAIN_CYCLES   = 60;

   localparam logic [TICK_W-1:0] TICKS_NONE = '0;
   localparam logic [TICK_W-1:0] TICKS_ALL  = '1;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_data;
   int unsigned fail_count;
   int unsigned pending;
   int unsigned quiet_cycles = 0;
   int unsigned stall_left = 0;

   ac_power_energy_accumulator_unit #(
      .WINDOW_SAMPLES(WINDOW_SAMPLES)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   acpea_energy_checker #(
      .WINDOW_SAMPLES(WINDOW_SAMPLES)
   ) u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // result side: short stalls mostly, a few long ones, and long free stretches
   always @(negedge clock) begin
      if (stall_left != 0) begin
         stall_left--;
      end else if (rsp_stall) begin
         rsp_stall <= 1'b0;
         stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(0, 12);
      end else begin
         rsp_stall <= 1'b1;
         stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80)
                                                  : $urandom_range(0, 3);
      end
   end

   // watchdog: cycles with no transfer on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
         $display("FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic req_type make_item(input logic [SAMPLE_W-1:0] v,
                                         input logic [SAMPLE_W-1:0] c,
                                         input logic [SAMPLE_W-1:0] pf,
                                         input logic [TICK_W-1:0] ticks);
      req_type r;
      r.voltage      = v;
      r.current      = c;
      r.power_factor = pf;
      {r.year_tick, r.month_tick, r.day_tick, r.hour_tick, r.minute_tick,
       r.second_tick} = ticks;
      return r;
   endfunction

   function automatic logic [SAMPLE_W-1:0] pick_sample();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         2:       return SAMPLE_W'($urandom_range(0, 255));
         default: return SAMPLE_W'($urandom);
      endcase
   endfunction

   function automatic logic [SAMPLE_W-1:0] pick_power_factor();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return 16'h8000;
         2:       return SAMPLE_W'($urandom_range(32769, 65535));
         3:       return '1;
         default: return SAMPLE_W'($urandom_range(0, 32768));
      endcase
   endfunction

   // second ticks come more than once a window on average so most windows get averaged
   function automatic req_type random_item();
      logic [TICK_W-1:0] ticks;
      if ($urandom_range(0, 19) == 0) begin
         ticks = TICK_W'($urandom);
      end else begin
         ticks = {$urandom_range(0, 499) == 0, $urandom_range(0, 499) == 0,
                  $urandom_range(0, 399) == 0, $urandom_range(0, 299) == 0,
                  $urandom_range(0, 149) == 0, $urandom_range(0, 44) == 0};
      end
      return make_item(pick_sample(), pick_sample(), pick_power_factor(), ticks);
   endfunction

   function automatic int unsigned pick_gap(input int unsigned idx);
      if ((idx % 300) < 60) return 0;
      case ($urandom_range(0, 19))
         0:             return $urandom_range(20, 60);
         1, 2, 3, 4, 5: return $urandom_range(1, 4);
         default:       return 0;
      endcase
   endfunction

   task automatic send_item(input req_type item, input int unsigned gap);
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      if (gap != 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending != 0) @(posedge clock);
   endtask

   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: flags before the window is full, extremes, saturated power
      send_item(make_item('0, '0, '0, TICKS_ALL), pick_gap(100));
      send_item(make_item('1, '1, 16'h8000, TICKS_NONE), pick_gap(100));
      send_item(make_item('1, '1, '1, TICKS_NONE), pick_gap(100));
      send_item(make_item('1, '1, 16'h8001, TICKS_NONE), pick_gap(100));
      send_item(make_item('1, '0, '1, TICKS_NONE), pick_gap(100));
      send_item(make_item('0, '1, '1, TICKS_NONE), pick_gap(100));
      send_item(make_item(16'h0001, 16'h0001, 16'h0001, TICKS_NONE), pick_gap(100));
      send_item(make_item(16'hAAAA, 16'h5555, 16'h5555, TICKS_NONE), pick_gap(100));
      send_item(make_item(16'h5555, 16'hAAAA, 16'h2AAA, TICKS_NONE), pick_gap(100));
      for (int k = 0; k < TICK_W; k++) begin
         send_item(make_item(SAMPLE_W'($urandom), SAMPLE_W'($urandom), 16'h8000,
                             TICKS_NONE | TICK_W'(1 << k)),
                   pick_gap(100));
      end
      send_item(make_item('1, '1, 16'h8000, TICKS_ALL), pick_gap(100));

      for (int unsigned idx = 0; idx < ITEM_COUNT; idx++) begin
         if (idx == PAUSE_AT) wait_drained();
         send_item(random_item(), pick_gap(idx));
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

[filelist.f]
hw/rtl/acpea_pkg.sv
hw/rtl/acpea_front.sv
hw/rtl/acpea_queue.sv
hw/rtl/acpea_div.sv
hw/rtl/acpea_back.sv
hw/rtl/ac_power_energy_accumulator_unit.sv
verif/acpea_energy_checker.sv
verif/ac_power_energy_accumulator_unit_tb.sv
